// ===== src/lpe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpe_pkg: shared types and constants of the LED pixel pulse encoder
// Pixel word format, queue entry, register indexes and reset values.
// ----------------------------------------------------------------------------
package lpe_pkg;

  localparam int unsigned BitsPerPixel = 24;
  localparam int unsigned BitIdxW      = $clog2(BitsPerPixel + 1);
  localparam int unsigned FifoDepth    = 2;

  localparam logic [8:0] HueWrap   = 9'd360;
  localparam logic [8:0] HueSegLen = 9'd60;
  localparam logic [6:0] FracSpan  = 7'd60;

  localparam logic [15:0] OneHighReset  = 16'd144;
  localparam logic [15:0] ZeroHighReset = 16'd72;
  localparam logic [7:0]  GuardReset    = 8'd50;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgOneHigh    = 2'd0,
    CfgZeroHigh   = 2'd1,
    CfgGuardSlots = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    SegRedGreenUp = 3'd0,
    SegRedDown    = 3'd1,
    SegBlueUp     = 3'd2,
    SegGreenDown  = 3'd3,
    SegRedUp      = 3'd4,
    SegBlueDown   = 3'd5
  } hue_seg_e;

  typedef struct packed {
    logic [BitsPerPixel-1:0] grb;
    logic                    guard;
  } pix_t;

  typedef struct packed {
    logic full;
    logic valid;
  } fifo_stat_t;

endpackage

// ===== src/lpe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpe_front: pixel intake and color resolution
// Accepts a pixel, converts hue to RGB when asked, packs GRB and guard flag.
// ----------------------------------------------------------------------------
module lpe_front import lpe_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       command_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic [8:0] hue_i,
  input  logic       last_led_i,
  input  logic [7:0] guard_slots_i,
  input  fifo_stat_t fifo_stat_i,
  output logic       push_o,
  output pix_t       push_data_o
);

  logic [8:0] h;
  logic [8:0] base;
  hue_seg_e   seg;
  logic [5:0] frac;
  logic [9:0] t_prod;
  logic [9:0] q_prod;
  logic [6:0] q_frac;
  logic [7:0] t_val;
  logic [7:0] q_val;
  logic [7:0] r;
  logic [7:0] g;
  logic [7:0] b;

  always_comb begin
    h = (hue_i >= HueWrap) ? hue_i - HueWrap : hue_i;
    priority if (h >= 5 * HueSegLen) begin
      seg = SegBlueDown;   base = 9'(5 * HueSegLen);
    end else if (h >= 4 * HueSegLen) begin
      seg = SegRedUp;      base = 9'(4 * HueSegLen);
    end else if (h >= 3 * HueSegLen) begin
      seg = SegGreenDown;  base = 9'(3 * HueSegLen);
    end else if (h >= 2 * HueSegLen) begin
      seg = SegBlueUp;     base = 9'(2 * HueSegLen);
    end else if (h >= HueSegLen) begin
      seg = SegRedDown;    base = HueSegLen;
    end else begin
      seg = SegRedGreenUp; base = 9'd0;
    end
    frac   = 6'(h - base);
    q_frac = FracSpan - {1'b0, frac};
    // 255/60 == 17/4
    t_prod = 10'({4'd0, frac} * 10'd17);
    q_prod = 10'({3'd0, q_frac} * 10'd17);
    t_val  = t_prod[9:2];
    q_val  = q_prod[9:2];
  end

  always_comb begin
    r = red_i;
    g = green_i;
    b = blue_i;
    if (command_i) begin
      unique case (seg)
        SegRedGreenUp: begin r = 8'hff;  g = t_val;  b = 8'h00;  end
        SegRedDown:    begin r = q_val;  g = 8'hff;  b = 8'h00;  end
        SegBlueUp:     begin r = 8'h00;  g = 8'hff;  b = t_val;  end
        SegGreenDown:  begin r = 8'h00;  g = q_val;  b = 8'hff;  end
        SegRedUp:      begin r = t_val;  g = 8'h00;  b = 8'hff;  end
        default:       begin r = 8'hff;  g = 8'h00;  b = q_val;  end
      endcase
    end
  end

  assign in_stall_o        = fifo_stat_i.full;
  assign push_o            = in_valid_i && !fifo_stat_i.full;
  assign push_data_o.grb   = {g, r, b};
  assign push_data_o.guard = last_led_i && (guard_slots_i != 8'd0);

endmodule

// ===== src/lpe_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpe_fifo: short pixel queue
// Decouples pixel intake from bit serialization.
// ----------------------------------------------------------------------------
module lpe_fifo import lpe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  pix_t       push_data_i,
  input  logic       pop_i,
  output pix_t       pop_data_o,
  output fifo_stat_t stat_o
);

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  pix_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o   = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CntW'(FifoDepth));
  assign stat_o.valid = (cnt_q != '0);

endmodule

// ===== src/lpe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpe_back: bit serializer
// Shifts GRB MSB first, one word per cycle unless stalled, then any guard.
// ----------------------------------------------------------------------------
module lpe_back import lpe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fifo_stat_t  fifo_stat_i,
  input  pix_t        pop_data_i,
  output logic        pop_o,
  input  logic [15:0] one_high_i,
  input  logic [15:0] zero_high_i,
  input  logic [7:0]  guard_slots_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] high_ticks_o,
  output logic [7:0]  slot_count_o,
  output logic        is_guard_o,
  output logic        last_o
);

  logic                    busy_q, busy_d;
  logic [BitIdxW-1:0]      idx_q, idx_d;
  logic [BitsPerPixel-1:0] sh_q, sh_d;
  logic                    guard_q, guard_d;
  logic                    out_valid_q, out_valid_d;
  logic [15:0]             high_q, high_d;
  logic [7:0]              slots_q, slots_d;
  logic                    is_guard_q, is_guard_d;
  logic                    last_q, last_d;
  logic                    load;
  logic                    guard_now;
  logic                    final_slot;

  always_comb begin
    load       = busy_q && (!out_valid_q || !out_stall_i);
    guard_now  = (idx_q == BitIdxW'(BitsPerPixel));
    final_slot = guard_now || ((idx_q == BitIdxW'(BitsPerPixel - 1)) && !guard_q);
    pop_o      = fifo_stat_i.valid && (!busy_q || (load && final_slot));

    out_valid_d = out_valid_q;
    high_d      = high_q;
    slots_d     = slots_q;
    is_guard_d  = is_guard_q;
    last_d      = last_q;
    if (load) begin
      out_valid_d = 1'b1;
      last_d      = final_slot;
      is_guard_d  = guard_now;
      if (guard_now) begin
        high_d  = 16'd0;
        slots_d = guard_slots_i;
      end else begin
        high_d  = sh_q[BitsPerPixel-1] ? one_high_i : zero_high_i;
        slots_d = 8'd1;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    busy_d  = busy_q;
    idx_d   = idx_q;
    sh_d    = sh_q;
    guard_d = guard_q;
    if (pop_o) begin
      busy_d  = 1'b1;
      idx_d   = '0;
      sh_d    = pop_data_i.grb;
      guard_d = pop_data_i.guard;
    end else if (load) begin
      busy_d = !final_slot;
      idx_d  = idx_q + 1'b1;
      sh_d   = {sh_q[BitsPerPixel-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    sh_q       <= sh_d;
    guard_q    <= guard_d;
    high_q     <= high_d;
    slots_q    <= slots_d;
    is_guard_q <= is_guard_d;
    last_q     <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign high_ticks_o = high_q;
  assign slot_count_o = slots_q;
  assign is_guard_o   = is_guard_q;
  assign last_o       = last_q;

endmodule

// ===== src/led_pixel_pulse_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pixel_pulse_encoder: addressable LED pulse encoder, top level
// Turns pixels into per-bit PWM compare words plus a frame reset guard.
// ----------------------------------------------------------------------------
// Each accepted pixel yields 24 words (GRB, MSB first), one per cycle from the
// serializer's output register while out_stall is low, and a 25th guard word
// when last_led is set and guard_slots is nonzero. A two-entry pixel queue
// sits between intake and serializer, so intake stalls only once two pixels
// are waiting. Registers: 0 one_high_ticks, 1 zero_high_ticks, 2 guard_slots;
// cfg_ready_o is always high.
module led_pixel_pulse_encoder import lpe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                command_i,
  input  logic [7:0]          red_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          blue_i,
  input  logic [8:0]          hue_i,
  input  logic                last_led_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [15:0]         high_ticks_o,
  output logic [7:0]          slot_count_o,
  output logic                is_guard_o,
  output logic                last_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [15:0] one_high_q;
  logic [15:0] zero_high_q;
  logic [7:0]  guard_slots_q;
  fifo_stat_t  fifo_stat;
  logic        push;
  pix_t        push_data;
  logic        pop;
  pix_t        pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_high_q    <= OneHighReset;
      zero_high_q   <= ZeroHighReset;
      guard_slots_q <= GuardReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgOneHigh:    one_high_q    <= cfg_data_i;
        CfgZeroHigh:   zero_high_q   <= cfg_data_i;
        CfgGuardSlots: guard_slots_q <= cfg_data_i[7:0];
        default:       ;
      endcase
    end
  end

  lpe_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .hue_i         (hue_i),
    .last_led_i    (last_led_i),
    .guard_slots_i (guard_slots_q),
    .fifo_stat_i   (fifo_stat),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  lpe_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (fifo_stat)
  );

  lpe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_stat_i   (fifo_stat),
    .pop_data_i    (pop_data),
    .pop_o         (pop),
    .one_high_i    (one_high_q),
    .zero_high_i   (zero_high_q),
    .guard_slots_i (guard_slots_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .high_ticks_o  (high_ticks_o),
    .slot_count_o  (slot_count_o),
    .is_guard_o    (is_guard_o),
    .last_o        (last_o)
  );

`ifndef SYNTH
  a_guard_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_guard_o |-> last_o && high_ticks_o == 16'd0 && slot_count_o != 8'd0)
    else $error("guard word malformed");

  a_data_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_guard_o |-> slot_count_o == 8'd1)
    else $error("data word slot count not one");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> fifo_stat.valid)
    else $error("pop from empty pixel queue");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_stat.full && !pop |=> fifo_stat.full)
    else $error("pixel queue lost an entry");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for led_pixel_pulse_encoder
// Sends pixels, some as RGB bytes and some as hue angles. For each accepted
// pixel it predicts the 24 GRB pulse words and any frame guard word, and it
// checks every output word in order. Runs go through several register
// settings and through mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import lpe_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 30;
  localparam int unsigned MaxPrinted    = 40;

  typedef struct packed {
    logic [15:0] high_ticks;
    logic [7:0]  slot_count;
    logic        is_guard;
    logic        last;
  } pulse_t;

  logic                clk = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                command_i = 1'b0;
  logic [7:0]          red_i = '0;
  logic [7:0]          green_i = '0;
  logic [7:0]          blue_i = '0;
  logic [8:0]          hue_i = '0;
  logic                last_led_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [15:0]         high_ticks_o;
  logic [7:0]          slot_count_o;
  logic                is_guard_o;
  logic                last_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  logic [15:0] cur_one_high  = OneHighReset;
  logic [15:0] cur_zero_high = ZeroHighReset;
  logic [7:0]  cur_guard     = GuardReset;

  pulse_t      pulse_q[$];
  int unsigned err_count = 0;
  int unsigned send_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;

  led_pixel_pulse_encoder dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .hue_i        (hue_i),
    .last_led_i   (last_led_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .high_ticks_o (high_ticks_o),
    .slot_count_o (slot_count_o),
    .is_guard_o   (is_guard_o),
    .last_o       (last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (err_count < MaxPrinted) begin
      $display("%0t ERROR %s: got %0h, want %0h", $realtime, what, got, want);
    end
    err_count++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [15:0] pick_ticks();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // GRB word of one pixel, hue path converted through six 60-degree ramps
  function automatic logic [23:0] grb_of_pixel(input logic cmd, input logic [7:0] r,
                                               input logic [7:0] g, input logic [7:0] b,
                                               input logic [8:0] hue);
    int unsigned h;
    int unsigned frac;
    int unsigned ramp_up;
    int unsigned ramp_dn;
    logic [7:0]  rr;
    logic [7:0]  gg;
    logic [7:0]  bb;
    rr = r;
    gg = g;
    bb = b;
    if (cmd) begin
      h       = hue % 360;
      frac    = h % 60;
      ramp_up = (255 * frac) / 60;
      ramp_dn = (255 * (60 - frac)) / 60;
      case (hue_seg_e'(3'(h / 60)))
        SegRedGreenUp: begin rr = 8'hFF;        gg = ramp_up[7:0]; bb = 8'h00;        end
        SegRedDown:    begin rr = ramp_dn[7:0]; gg = 8'hFF;        bb = 8'h00;        end
        SegBlueUp:     begin rr = 8'h00;        gg = 8'hFF;        bb = ramp_up[7:0]; end
        SegGreenDown:  begin rr = 8'h00;        gg = ramp_dn[7:0]; bb = 8'hFF;        end
        SegRedUp:      begin rr = ramp_up[7:0]; gg = 8'h00;        bb = 8'hFF;        end
        default:       begin rr = 8'hFF;        gg = 8'h00;        bb = ramp_dn[7:0]; end
      endcase
    end
    return {gg, rr, bb};
  endfunction

  task automatic send_pixel(input logic cmd, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic [8:0] hue,
                            input logic last_px);
    logic [23:0] grb;
    logic        guard;
    int          k;
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    red_i      <= r;
    green_i    <= g;
    blue_i     <= b;
    hue_i      <= hue;
    last_led_i <= last_px;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    grb   = grb_of_pixel(cmd, r, g, b, hue);
    guard = last_px && (cur_guard != 8'd0);
    for (k = 0; k < 24; k++) begin
      pulse_q.push_back('{grb[23 - k] ? cur_one_high : cur_zero_high, 8'd1, 1'b0,
                          !guard && (k == 23)});
    end
    if (guard) begin
      pulse_q.push_back('{16'd0, cur_guard, 1'b1, 1'b1});
    end
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    case (idx)
      CfgOneHigh:    cur_one_high  = data;
      CfgZeroHigh:   cur_zero_high = data;
      CfgGuardSlots: cur_guard     = data[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid_i <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain_pulses();
    in_valid_i <= 1'b0;
    while (pulse_q.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic test_direct_colors();
    send_pixel(1'b0, 8'h00, 8'h00, 8'h00, 9'h1FF, 1'b0);
    send_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF, 9'h000, 1'b0);
    send_pixel(1'b0, 8'hA5, 8'h5A, 8'hC3, 9'h155, 1'b0);
    send_pixel(1'b0, 8'h81, 8'h7E, 8'h18, 9'h0AA, 1'b1);
    drain_pulses();
  endtask

  task automatic test_hue_wrap();
    int unsigned hues[14] = '{0, 30, 59, 60, 119, 120, 180, 240, 299, 300, 359, 360,
                              419, 511};
    foreach (hues[i]) begin
      send_pixel(1'b1, pick_byte(), pick_byte(), pick_byte(), 9'(hues[i]), i == 13);
    end
    drain_pulses();
  endtask

  task automatic test_registers();
    write_reg(CfgOneHigh, 16'hFFFF);
    write_reg(CfgZeroHigh, 16'h0000);
    write_reg(CfgGuardSlots, 16'h0000);
    send_pixel(1'b0, 8'hA5, 8'h3C, 8'h0F, 9'd0, 1'b1);
    send_pixel(1'b1, 8'h00, 8'h00, 8'h00, 9'd90, 1'b1);
    drain_pulses();
    write_reg(CfgGuardSlots, 16'hABFF);
    write_reg(CfgIdxSpare, 16'h1234);
    send_pixel(1'b1, 8'hFF, 8'h00, 8'hFF, 9'd200, 1'b0);
    send_pixel(1'b0, 8'h12, 8'h34, 8'h56, 9'd400, 1'b1);
    drain_pulses();
    write_reg(CfgOneHigh, 16'h0000);
    write_reg(CfgZeroHigh, 16'hFFFF);
    write_reg(CfgGuardSlots, 16'h0001);
    send_pixel(1'b0, 8'hF0, 8'h0F, 8'h99, 9'd0, 1'b0);
    send_pixel(1'b1, 8'h00, 8'h00, 8'h00, 9'd330, 1'b1);
    drain_pulses();
  endtask

  // frames of a few pixels with last_led on the final one; some noise on last_led
  task automatic test_random_frames(input int unsigned n_pixels, input int unsigned gap_pct,
                                    input int unsigned hold_pct);
    int unsigned sent;
    int unsigned frame_len;
    int unsigned k;
    logic        last_px;
    write_reg(CfgOneHigh, pick_ticks());
    write_reg(CfgZeroHigh, pick_ticks());
    write_reg(CfgGuardSlots, {8'($urandom_range(255)),
                              ($urandom_range(2) == 0) ? 8'h00 :
                              ($urandom_range(1) == 0) ? 8'hFF : 8'($urandom_range(255))});
    write_reg(CfgIdxSpare, 16'($urandom_range(65535)));
    send_pct  = gap_pct;
    stall_pct = hold_pct;
    sent = 0;
    while (sent < n_pixels) begin
      frame_len = $urandom_range(1, 6);
      for (k = 0; k < frame_len; k++) begin
        if ($urandom_range(9) == 0) begin
          last_px = 1'($urandom_range(1));
        end else begin
          last_px = (k == frame_len - 1);
        end
        send_pixel(1'($urandom_range(1)), pick_byte(), pick_byte(), pick_byte(),
                   9'($urandom_range(511)), last_px);
        sent++;
      end
    end
    drain_pulses();
    send_pct  = 0;
    stall_pct = 0;
  endtask

  always @(posedge clk) begin : check_words
    pulse_t got;
    pulse_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{high_ticks_o, slot_count_o, is_guard_o, last_o};
      if (pulse_q.size() == 0) begin
        report_mismatch("word with nothing pending, high_ticks", got.high_ticks, 0);
      end else begin
        want = pulse_q.pop_front();
        if (got.high_ticks !== want.high_ticks)
          report_mismatch("high_ticks", got.high_ticks, want.high_ticks);
        if (got.slot_count !== want.slot_count)
          report_mismatch("slot_count", got.slot_count, want.slot_count);
        if (got.is_guard !== want.is_guard)
          report_mismatch("is_guard", got.is_guard, want.is_guard);
        if (got.last !== want.last)
          report_mismatch("last", got.last, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
                 (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WatchdogLimit) begin
      $display("%0t ERROR watchdog: no handshake for %0d cycles", $realtime, WatchdogLimit);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);
    test_direct_colors();
    test_hue_wrap();
    test_registers();
    test_random_frames(74, 0, 0);
    test_random_frames(74, 48, 0);
    test_random_frames(74, 0, 48);
    test_random_frames(74, 33, 33);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
